### rtl/fpt_pkg.sv
// Shared constants, tables and control structs of the flow pulse totalizer.
package fpt_pkg;

  localparam int COUNT_W = 64;    // pulse counter width
  localparam int VOL_W   = 64;    // volume and rate result width
  localparam int CAL_W   = 32;    // calibration factor width
  localparam int NUM_W   = 104;   // dividend width (largest product is 64 x 40 bits)
  localparam int DEN_W   = 76;    // divisor width (48-bit (dt-1)*cal product x 28-bit ratio)
  localparam int MB_W    = 40;    // multiplier operand shifted out one bit a cycle
  localparam int DCNT_W  = 7;     // divider step counter, holds NUM_W

  // Operation codes
  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_CAPTURE   = 2'd1;
  localparam logic [1:0] OP_CLR_ACC   = 2'd2;
  localparam logic [1:0] OP_CLR_TRIP  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_CAL      = 2'd0;
  localparam logic [1:0] REG_VUNIT    = 2'd1;
  localparam logic [1:0] REG_TUNIT    = 2'd2;

  localparam logic [CAL_W-1:0] CAL_RST   = 32'd1000;
  localparam logic [2:0]       VUNIT_RST = 3'd4;
  localparam logic [1:0]       TUNIT_RST = 2'd0;

  // Multiplier operand selects
  localparam logic [2:0] MS_DV = 3'd0;  // cal * num -> volume divisor
  localparam logic [2:0] MS_NA = 3'd1;  // accumulated * 10^6*den
  localparam logic [2:0] MS_NT = 3'd2;  // trip * 10^6*den
  localparam logic [2:0] MS_T  = 3'd3;  // (dt-1) * cal
  localparam logic [2:0] MS_DR = 3'd4;  // (dt-1)*cal product * num -> rate divisor
  localparam logic [2:0] MS_NR = 3'd5;  // dp*ticks*secs * 10^6*den

  // Divider destination selects
  localparam logic [1:0] DS_A = 2'd0;
  localparam logic [1:0] DS_T = 2'd1;
  localparam logic [1:0] DS_R = 2'd2;

  typedef struct packed {
    logic       take;      // input transaction accepted this cycle
    logic       apply;
    logic       mul_go;
    logic [2:0] msel;
    logic       div_go;
    logic [1:0] dsel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic rate_calc;   // accepted capture with a usable window
    logic out_free;
  } stat_t;

  // Liters per unit, numerator
  function automatic logic [27:0] unit_num(input logic [2:0] vu);
    logic [27:0] r;
    case (vu)
      3'd1:    r = 28'd158987304;
      3'd2:    r = 28'd378541;
      3'd5:    r = 28'd1000;
      default: r = 28'd1;
    endcase
    return r;
  endfunction

  // 10^6 times the liters-per-unit denominator
  function automatic logic [MB_W-1:0] unit_den_k(input logic [2:0] vu);
    logic [MB_W-1:0] r;
    case (vu)
      3'd1:    r = 40'd1000000000000;
      3'd2:    r = 40'd100000000000;
      default: r = 40'd1000000;
    endcase
    return r;
  endfunction

  // Tick rate times seconds per time unit (32768 Hz tick)
  function automatic logic [31:0] tick_secs(input logic [1:0] tu);
    logic [31:0] r;
    case (tu)
      2'd1:    r = 32'd1966080;
      2'd2:    r = 32'd117964800;
      2'd3:    r = 32'd2831155200;
      default: r = 32'd32768;
    endcase
    return r;
  endfunction

endpackage

### rtl/fpt_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, stops when the bits run out.
module fpt_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [63:0]                 a,
  input  logic [fpt_pkg::MB_W-1:0]    b,
  output logic                        done,
  output logic [fpt_pkg::NUM_W-1:0]   p
);

  logic                       busy_r, busy_nxt;
  logic [fpt_pkg::NUM_W-1:0]  a_r, a_nxt;
  logic [fpt_pkg::MB_W-1:0]   b_r, b_nxt;
  logic [fpt_pkg::NUM_W-1:0]  p_r, p_nxt;

  assign done = busy_r && (b_r == '0);
  assign p    = p_r;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        a_nxt    = {{(fpt_pkg::NUM_W-64){1'b0}}, a};
        b_nxt    = b;
        p_nxt    = '0;
      end
    end else if (b_r == '0) begin
      busy_nxt = 1'b0;
    end else begin
      if (b_r[0]) p_nxt = p_r + a_r;
      a_nxt = {a_r[fpt_pkg::NUM_W-2:0], 1'b0};
      b_nxt = {1'b0, b_r[fpt_pkg::MB_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

endmodule

### rtl/fpt_div.sv
// Restoring divider, one quotient bit per cycle, saturating 64-bit quotient.
module fpt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [fpt_pkg::NUM_W-1:0]   n,
  input  logic [fpt_pkg::DEN_W-1:0]   d,
  output logic                        done,
  output logic [fpt_pkg::VOL_W-1:0]   q
);

  logic                        busy_r, busy_nxt;
  logic [fpt_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [fpt_pkg::NUM_W-1:0]   n_r, n_nxt;
  logic [fpt_pkg::NUM_W-1:0]   q_r, q_nxt;
  logic [fpt_pkg::DEN_W-1:0]   d_r, d_nxt;
  logic [fpt_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [fpt_pkg::DEN_W:0]     trial;
  logic [fpt_pkg::DEN_W:0]     diff;

  assign done  = busy_r && (cnt_r == '0);
  assign trial = {rem_r, n_r[fpt_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, d_r};

  // Zero divisor or a quotient beyond 64 bits saturates
  assign q = ((d_r == '0) || (q_r[fpt_pkg::NUM_W-1:fpt_pkg::VOL_W] != '0)) ?
             {fpt_pkg::VOL_W{1'b1}} : q_r[fpt_pkg::VOL_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        cnt_nxt  = fpt_pkg::DCNT_W'(fpt_pkg::NUM_W);
        n_nxt    = n;
        d_nxt    = d;
        q_nxt    = '0;
        rem_nxt  = '0;
      end
    end else if (cnt_r == '0) begin
      busy_nxt = 1'b0;
    end else begin
      cnt_nxt = cnt_r - 1'b1;
      n_nxt   = {n_r[fpt_pkg::NUM_W-2:0], 1'b0};
      if (!diff[fpt_pkg::DEN_W]) begin
        rem_nxt = diff[fpt_pkg::DEN_W-1:0];
        q_nxt   = {q_r[fpt_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[fpt_pkg::DEN_W-1:0];
        q_nxt   = {q_r[fpt_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

endmodule

### rtl/fpt_dp.sv
// Datapath: registers, counters, operand selection, multiplier, divider, output slot.
module fpt_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_idx,
  input  logic [31:0]            cfg_wdata,
  input  logic [1:0]             in_op,
  input  logic [63:0]            in_data,
  input  fpt_pkg::cmd_t          cmd,
  output fpt_pkg::stat_t         stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [199:0]           out_data
);

  logic [fpt_pkg::CAL_W-1:0]    cal_r;
  logic [2:0]                   vunit_r;
  logic [1:0]                   tunit_r;
  logic [fpt_pkg::COUNT_W-1:0]  acc_r, trip_r;
  logic [fpt_pkg::VOL_W-1:0]    rate_r;
  logic                         err_r;
  logic [1:0]                   op_r;
  logic [31:0]                  delta_r;
  logic [15:0]                  dp_r, dt_r;
  logic                         rcalc_r;
  logic [63:0]                  t_r;
  logic [fpt_pkg::DEN_W-1:0]    dv_r, dr_r;
  logic [fpt_pkg::NUM_W-1:0]    num_r;
  logic [fpt_pkg::VOL_W-1:0]    vacc_r, vtrip_r;
  logic                         oval_r;
  logic [199:0]                 odata_r;

  logic [63:0]                  ma;
  logic [fpt_pkg::MB_W-1:0]     mb;
  logic                         mdone, ddone;
  logic [fpt_pkg::NUM_W-1:0]    mp;
  logic [fpt_pkg::DEN_W-1:0]    dd;
  logic [fpt_pkg::VOL_W-1:0]    dq;
  logic [47:0]                  win_prod;

  // pulses times tick rate times seconds per time unit
  assign win_prod = dp_r * fpt_pkg::tick_secs(tunit_r);

  always_comb begin
    case (cmd.msel)
      fpt_pkg::MS_DV: begin
        ma = {32'd0, cal_r};
        mb = {12'd0, fpt_pkg::unit_num(vunit_r)};
      end
      fpt_pkg::MS_NA: begin
        ma = acc_r;
        mb = fpt_pkg::unit_den_k(vunit_r);
      end
      fpt_pkg::MS_NT: begin
        ma = trip_r;
        mb = fpt_pkg::unit_den_k(vunit_r);
      end
      fpt_pkg::MS_T: begin
        ma = {32'd0, cal_r};
        mb = {24'd0, dt_r - 16'd1};
      end
      fpt_pkg::MS_DR: begin
        ma = t_r;
        mb = {12'd0, fpt_pkg::unit_num(vunit_r)};
      end
      fpt_pkg::MS_NR: begin
        ma = {16'd0, win_prod};
        mb = fpt_pkg::unit_den_k(vunit_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign dd = (cmd.dsel == fpt_pkg::DS_R) ? dr_r : dv_r;

  fpt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .p     (mp)
  );

  fpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .n     (num_r),
    .d     (dd),
    .done  (ddone),
    .q     (dq)
  );

  assign stat.mul_done  = mdone;
  assign stat.div_done  = ddone;
  assign stat.rate_calc = rcalc_r;
  assign stat.out_free  = !oval_r || out_ready;
  assign out_valid      = oval_r;
  assign out_data       = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r   <= fpt_pkg::CAL_RST;
      vunit_r <= fpt_pkg::VUNIT_RST;
      tunit_r <= fpt_pkg::TUNIT_RST;
      acc_r   <= '0;
      trip_r  <= '0;
      rate_r  <= '0;
      err_r   <= 1'b0;
      rcalc_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          fpt_pkg::REG_CAL:   cal_r   <= cfg_wdata;
          fpt_pkg::REG_VUNIT: vunit_r <= cfg_wdata[2:0];
          fpt_pkg::REG_TUNIT: tunit_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (cmd.apply) begin
        rcalc_r <= 1'b0;
        case (op_r)
          fpt_pkg::OP_ADD: begin
            acc_r  <= acc_r + {32'd0, delta_r};
            trip_r <= trip_r + {32'd0, delta_r};
          end
          fpt_pkg::OP_CAPTURE: begin
            if (dt_r <= 16'd1) begin
              rate_r <= '0;
              err_r  <= 1'b1;
            end else begin
              rcalc_r <= 1'b1;
            end
          end
          fpt_pkg::OP_CLR_ACC:  acc_r  <= '0;
          default:              trip_r <= '0;
        endcase
      end
      if (ddone && (cmd.dsel == fpt_pkg::DS_R)) begin
        rate_r  <= dq;
        err_r   <= 1'b0;
        rcalc_r <= 1'b0;
      end
      if (cmd.out_load)   oval_r <= 1'b1;
      else if (out_ready) oval_r <= 1'b0;
    end
  end

  // Input fields captured at acceptance; apply runs in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= in_op;
      delta_r <= in_data[31:0];
      dp_r    <= in_data[47:32];
      dt_r    <= in_data[63:48];
    end
    if (mdone) begin
      case (cmd.msel)
        fpt_pkg::MS_DV: dv_r  <= mp[fpt_pkg::DEN_W-1:0];
        fpt_pkg::MS_T:  t_r   <= mp[63:0];
        fpt_pkg::MS_DR: dr_r  <= mp[fpt_pkg::DEN_W-1:0];
        default:        num_r <= mp;
      endcase
    end
    if (ddone) begin
      case (cmd.dsel)
        fpt_pkg::DS_A: vacc_r  <= dq;
        fpt_pkg::DS_T: vtrip_r <= dq;
        default: ;
      endcase
    end
    if (cmd.out_load) odata_r <= {7'd0, err_r, rate_r, vtrip_r, vacc_r};
  end

endmodule

### rtl/fpt_ctrl.sv
// Controller: sequences operation, multiplies and divides for one transaction.
module fpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fpt_pkg::stat_t  stat,
  output fpt_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_APPLY = 4'd1;
  localparam logic [3:0] S_MUL_T = 4'd2;
  localparam logic [3:0] S_MUL_DR = 4'd3;
  localparam logic [3:0] S_MUL_NR = 4'd4;
  localparam logic [3:0] S_DIV_R = 4'd5;
  localparam logic [3:0] S_MUL_DV = 4'd6;
  localparam logic [3:0] S_MUL_NA = 4'd7;
  localparam logic [3:0] S_DIV_A = 4'd8;
  localparam logic [3:0] S_MUL_NT = 4'd9;
  localparam logic [3:0] S_DIV_T = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.msel     = fpt_pkg::MS_DV;
    cmd.dsel     = fpt_pkg::DS_A;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_MUL_DV;
      end
      S_MUL_DV: begin
        // rate_calc is valid from here, in the cycle after apply
        if (stat.rate_calc) begin
          state_nxt = S_MUL_T;
        end else begin
          cmd.mul_go = 1'b1;
          if (stat.mul_done) state_nxt = S_MUL_NA;
        end
      end
      S_MUL_T: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = fpt_pkg::MS_T;
        if (stat.mul_done) state_nxt = S_MUL_DR;
      end
      S_MUL_DR: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = fpt_pkg::MS_DR;
        if (stat.mul_done) state_nxt = S_MUL_NR;
      end
      S_MUL_NR: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = fpt_pkg::MS_NR;
        if (stat.mul_done) state_nxt = S_DIV_R;
      end
      S_DIV_R: begin
        cmd.div_go = 1'b1;
        cmd.dsel   = fpt_pkg::DS_R;
        if (stat.div_done) state_nxt = S_MUL_DV;
      end
      S_MUL_NA: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = fpt_pkg::MS_NA;
        if (stat.mul_done) state_nxt = S_DIV_A;
      end
      S_DIV_A: begin
        cmd.div_go = 1'b1;
        cmd.dsel   = fpt_pkg::DS_A;
        if (stat.div_done) state_nxt = S_MUL_NT;
      end
      S_MUL_NT: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = fpt_pkg::MS_NT;
        if (stat.mul_done) state_nxt = S_DIV_T;
      end
      S_DIV_T: begin
        cmd.div_go = 1'b1;
        cmd.dsel   = fpt_pkg::DS_T;
        if (stat.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.msel = fpt_pkg::MS_NT;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/flow_pulse_totalizer.sv
// Flow meter pulse totalizer: top level joining controller and datapath.
//
// Keeps wrapping 64-bit accumulated and trip pulse counters and answers every
// input transaction with one result transaction: both volumes in thousandths
// of the selected unit, the held flow rate and its error flag. A single
// shift-add multiplier forms three to six products per transaction from
// operands of up to 40 bits, and a single restoring divider retires one
// quotient bit per cycle for two or three quotients. A capture with a usable
// window adds the rate product chain and divide. The next transaction is
// taken once the current one has moved into the output register, even if
// that result still waits for out_tready. Configuration writes land at once
// and must only be issued while the block is idle.
module flow_pulse_totalizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [31:0]   cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // pulse_count[31:0], capture_pulses[47:32],
                                    // capture_ticks[63:48]
  input  logic [1:0]    in_tuser,   // op[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [199:0]  out_tdata   // accumulated_x1000[63:0], trip_x1000[127:64],
                                    // rate_x1000[191:128], rate_error[192]
);

  fpt_pkg::cmd_t  cmd;
  fpt_pkg::stat_t stat;

  // Sequence the work of one transaction
  fpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold state, counters and arithmetic units
  fpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the flow pulse totalizer stream block.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // Volume unit and time base codes, as the configuration registers take them
  localparam logic [2:0] VU_NONE   = 3'd0;
  localparam logic [2:0] VU_BARREL = 3'd1;
  localparam logic [2:0] VU_GALLON = 3'd2;
  localparam logic [2:0] VU_KG     = 3'd3;
  localparam logic [2:0] VU_LITER  = 3'd4;
  localparam logic [2:0] VU_M3     = 3'd5;
  localparam logic [2:0] VU_ME     = 3'd6;
  localparam logic [2:0] VU_SPARE  = 3'd7;
  localparam logic [1:0] TU_SEC    = 2'd0;
  localparam logic [1:0] TU_MIN    = 2'd1;
  localparam logic [1:0] TU_HOUR   = 2'd2;
  localparam logic [1:0] TU_DAY    = 2'd3;

  // Idle modes of a phase
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  localparam int  NUM_PHASES   = 8;
  localparam int  PHASE_ITEMS  = 180;
  localparam int  DRAIN_CYCLES = 700;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] delta;
    logic [15:0] cap_pulses;
    logic [15:0] cap_ticks;
  } meter_op_t;

  typedef struct packed {
    logic [63:0] acc_vol;
    logic [63:0] trip_vol;
    logic [63:0] rate;
    logic        rate_err;
  } totals_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [1:0]    cfg_idx;
  logic [31:0]   cfg_wdata;
  logic          in_tvalid;
  logic          in_tready;
  logic [63:0]   in_tdata;   // pulse_count[31:0], capture_pulses[47:32], capture_ticks[63:48]
  logic [1:0]    in_tuser;   // op[1:0]
  logic          out_tvalid;
  logic          out_tready;
  logic [199:0]  out_tdata;  // acc[63:0], trip[127:64], rate[191:128], rate_error[192]

  flow_pulse_totalizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow of the block's registers and counters
  logic [31:0] cal_shadow;
  logic [2:0]  vunit_shadow;
  logic [1:0]  tunit_shadow;
  logic [63:0] acc_pulses;
  logic [63:0] trip_pulses;
  logic [63:0] rate_hold;
  logic        rate_err_hold;

  meter_op_t pending_ops[$];
  totals_t   expected_totals[$];
  int        idle_mode;
  int        fail_count;
  longint    cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Liters per unit as num/den, with 10^6 folded into den
  function automatic logic [191:0] liters_num(input logic [2:0] vu);
    case (vu)
      VU_BARREL: return 192'd158987304;
      VU_GALLON: return 192'd378541;
      VU_M3:     return 192'd1000;
      default:   return 192'd1;
    endcase
  endfunction

  function automatic logic [191:0] liters_den_k(input logic [2:0] vu);
    case (vu)
      VU_BARREL: return 192'd1000000000000;
      VU_GALLON: return 192'd100000000000;
      default:   return 192'd1000000;
    endcase
  endfunction

  function automatic logic [191:0] secs_of(input logic [1:0] tu);
    case (tu)
      TU_MIN:  return 192'd60;
      TU_HOUR: return 192'd3600;
      TU_DAY:  return 192'd86400;
      default: return 192'd1;
    endcase
  endfunction

  // Saturating quotient; a zero divisor saturates too
  function automatic logic [63:0] sat_quot(input logic [191:0] n, input logic [191:0] d);
    logic [191:0] q;
    if (d == '0) return '1;
    q = n / d;
    if (q[191:64] != '0) return '1;
    return q[63:0];
  endfunction

  function automatic logic [63:0] pulses_to_vol(input logic [63:0] p);
    return sat_quot({128'd0, p} * liters_den_k(vunit_shadow),
                    {160'd0, cal_shadow} * liters_num(vunit_shadow));
  endfunction

  // Apply one transaction to the shadow state and return the totals it yields
  function automatic totals_t totalize(input meter_op_t m);
    totals_t      t;
    logic [191:0] n;
    logic [191:0] d;
    case (m.op)
      fpt_pkg::OP_ADD: begin
        acc_pulses  = acc_pulses + {32'd0, m.delta};
        trip_pulses = trip_pulses + {32'd0, m.delta};
      end
      fpt_pkg::OP_CAPTURE: begin
        if (m.cap_ticks <= 16'd1) begin
          rate_hold     = '0;
          rate_err_hold = 1'b1;
        end else begin
          n = {176'd0, m.cap_pulses} * 192'd32768 * secs_of(tunit_shadow)
              * liters_den_k(vunit_shadow);
          d = {176'd0, m.cap_ticks - 16'd1} * {160'd0, cal_shadow}
              * liters_num(vunit_shadow);
          rate_hold     = sat_quot(n, d);
          rate_err_hold = 1'b0;
        end
      end
      fpt_pkg::OP_CLR_ACC:  acc_pulses = '0;
      default:              trip_pulses = '0;
    endcase
    t.acc_vol  = pulses_to_vol(acc_pulses);
    t.trip_vol = pulses_to_vol(trip_pulses);
    t.rate     = rate_hold;
    t.rate_err = rate_err_hold;
    return t;
  endfunction

  // Random transaction: mostly adds and captures, with edge-heavy values
  function automatic meter_op_t rand_op();
    meter_op_t m;
    int        r;
    r = $urandom_range(99);
    if (r < 50) m.op = fpt_pkg::OP_ADD;
    else if (r < 80) m.op = fpt_pkg::OP_CAPTURE;
    else if (r < 90) m.op = fpt_pkg::OP_CLR_ACC;
    else m.op = fpt_pkg::OP_CLR_TRIP;
    case ($urandom_range(3))
      0:       m.delta = $urandom_range(1000);
      1:       m.delta = 32'hFFFF_FFFF - $urandom_range(3);
      default: m.delta = $urandom;
    endcase
    m.cap_pulses = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom);
    case ($urandom_range(7))
      0:       m.cap_ticks = 16'($urandom_range(1));
      1:       m.cap_ticks = 16'd2;
      2:       m.cap_ticks = 16'hFFFF;
      default: m.cap_ticks = 16'($urandom);
    endcase
    return m;
  endfunction

  function automatic meter_op_t mk_op(input logic [1:0] op, input logic [31:0] delta,
                                      input logic [15:0] cp, input logic [15:0] ct);
    meter_op_t m;
    m.op = op;
    m.delta = delta;
    m.cap_pulses = cp;
    m.cap_ticks = ct;
    return m;
  endfunction

  // Driver: present the next pending transaction, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() > 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 72) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 6))) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_ops[0].op;
        in_tdata  <= {pending_ops[0].cap_ticks, pending_ops[0].cap_pulses,
                      pending_ops[0].delta};
        void'(pending_ops.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if ((idle_mode == IDLE_RECV && $urandom_range(99) < 72) ||
        (idle_mode == IDLE_BOTH && $urandom_range(99) < 6))
      out_tready <= 1'b0;
    else
      out_tready <= 1'b1;
  end

  // Monitor: predict on each accepted input, check each accepted result
  always @(posedge clk) begin
    totals_t got;
    totals_t exp_t;
    if (rst_n && in_tvalid && in_tready)
      expected_totals.push_back(totalize(mk_op(in_tuser, in_tdata[31:0], in_tdata[47:32],
                                               in_tdata[63:48])));
    if (rst_n && out_tvalid && out_tready) begin
      got.acc_vol  = out_tdata[63:0];
      got.trip_vol = out_tdata[127:64];
      got.rate     = out_tdata[191:128];
      got.rate_err = out_tdata[192];
      if (expected_totals.size() == 0) begin
        $error("unexpected result transaction: %h", out_tdata[192:0]);
        fail_count++;
      end else begin
        exp_t = expected_totals.pop_front();
        if (got.acc_vol !== exp_t.acc_vol) begin
          $error("accumulated_x1000: expected %0d, got %0d", exp_t.acc_vol, got.acc_vol);
          fail_count++;
        end
        if (got.trip_vol !== exp_t.trip_vol) begin
          $error("trip_x1000: expected %0d, got %0d", exp_t.trip_vol, got.trip_vol);
          fail_count++;
        end
        if (got.rate !== exp_t.rate) begin
          $error("rate_x1000: expected %0d, got %0d", exp_t.rate, got.rate);
          fail_count++;
        end
        if (got.rate_err !== exp_t.rate_err) begin
          $error("rate_error: expected %0d, got %0d", exp_t.rate_err, got.rate_err);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // Mirror the write once it has landed
    case (idx)
      fpt_pkg::REG_CAL:   cal_shadow   = val;
      fpt_pkg::REG_VUNIT: vunit_shadow = val[2:0];
      default:            tunit_shadow = val[1:0];
    endcase
  endtask

  // Wait until every queued transaction went in and every result came out
  task automatic drain();
    @(negedge clk);
    while (pending_ops.size() > 0 || in_tvalid || expected_totals.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    logic [31:0] cal_sets[NUM_PHASES];
    logic [2:0]  vu_sets[NUM_PHASES];
    logic [1:0]  tu_sets[NUM_PHASES];
    cal_sets = '{32'd1000, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd0};
    vu_sets  = '{VU_LITER, VU_SPARE, VU_BARREL, VU_GALLON, VU_M3, VU_NONE, VU_KG, VU_ME};
    tu_sets  = '{TU_SEC, TU_DAY, TU_DAY, TU_MIN, TU_HOUR, TU_SEC, TU_HOUR, TU_DAY};
    // Random calibration factors for the later phases
    cal_sets[4] = $urandom;
    cal_sets[5] = $urandom_range(5000, 1);
    cal_sets[7] = $urandom;

    fail_count    = 0;
    cycle_count   = 0;
    idle_mode     = IDLE_NONE;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = fpt_pkg::REG_CAL;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = fpt_pkg::OP_ADD;
    out_tready    = 1'b0;
    cal_shadow    = fpt_pkg::CAL_RST;
    vunit_shadow  = fpt_pkg::VUNIT_RST;
    tunit_shadow  = fpt_pkg::TUNIT_RST;
    acc_pulses    = '0;
    trip_pulses   = '0;
    rate_hold     = '0;
    rate_err_hold = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at reset settings: extremes, every op, short windows
    @(negedge clk);
    pending_ops.push_back(mk_op(fpt_pkg::OP_ADD, 32'd0, 16'd0, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    pending_ops.push_back(mk_op(fpt_pkg::OP_ADD, 32'd1234, 16'd0, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'd500, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'd500, 16'd1));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'd500, 16'd2));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'hFFFF, 16'd2));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'd0, 16'hFFFF));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CLR_TRIP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    pending_ops.push_back(mk_op(fpt_pkg::OP_ADD, 32'd77, 16'd0, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CLR_ACC, 32'd0, 16'd0, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_ADD, 32'hFFFF_FFFF, 16'd0, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CLR_TRIP, 32'd0, 16'd0, 16'd0));
    pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'd1, 16'd1));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Block is idle here: every result has arrived and each input gives one
      write_reg(fpt_pkg::REG_CAL, cal_sets[ph]);
      write_reg(fpt_pkg::REG_VUNIT, {29'd0, vu_sets[ph]});
      write_reg(fpt_pkg::REG_TUNIT, {30'd0, tu_sets[ph]});
      idle_mode = ph % 4;
      @(negedge clk);
      // A held rate survives the register change; report it first
      pending_ops.push_back(mk_op(fpt_pkg::OP_CLR_TRIP, 32'd0, 16'd0, 16'd0));
      pending_ops.push_back(mk_op(fpt_pkg::OP_CAPTURE, 32'd0, 16'hFFFF, 16'd2));
      for (int i = 0; i < PHASE_ITEMS; i++)
        pending_ops.push_back(rand_op());
      drain();
    end

    idle_mode = IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_totals.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
